// ===== src/ntft_pkg.sv =====
// types, constants and codes shared by the nearest-two facility table
`default_nettype none
package ntft_pkg;
   localparam int MAX_NODES = 256;
   localparam int IDX_W     = $clog2(MAX_NODES);
   localparam int CNT_W     = IDX_W + 1;
   localparam int DIST_W    = 16;
   localparam int MAT_DEPTH = MAX_NODES * MAX_NODES;

   localparam int OP_W     = 2;
   localparam int NODE_W   = 8;
   localparam int CSR_W    = 9;
   localparam int STATUS_W = 2;

   localparam logic [DIST_W-1:0] DIST_INF = {DIST_W{1'b1}};
   localparam logic [CNT_W-1:0]  NO_FAC   = CNT_W'(MAX_NODES);

   typedef enum logic [OP_W-1:0] {
      OP_LOAD  = 2'd0,
      OP_CLEAR = 2'd1,
      OP_OPEN  = 2'd2,
      OP_CLOSE = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK           = 2'd0,
      ST_ALREADY_OPEN = 2'd1,
      ST_NOT_OPEN     = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      MODE_ADD,
      MODE_DEL,
      MODE_READ
   } mode_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_RESCAN
   } state_type;

   typedef struct packed {
      logic [CNT_W-1:0]  nf;
      logic [DIST_W-1:0] nd;
      logic [CNT_W-1:0]  sf;
      logic [DIST_W-1:0] sd;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);
   localparam entry_type RESET_ENTRY = '{nf: NO_FAC, nd: DIST_INF, sf: NO_FAC, sd: DIST_INF};
endpackage
`default_nettype wire

// ===== src/ntft_if.sv =====
// request and response channel interfaces
`default_nettype none
interface ntft_req_if import ntft_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     op;
   logic [NODE_W-1:0]   node;
   logic [NODE_W-1:0]   other_node;
   logic [DIST_W-1:0]   distance;
   modport source (output valid, op, node, other_node, distance, input ready);
   modport sink (input valid, op, node, other_node, distance, output ready);
endinterface

interface ntft_rsp_if import ntft_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [DIST_W-1:0]   max_service_distance;
   logic [CSR_W-1:0]    open_count;
   logic [STATUS_W-1:0] status;
   modport source (output valid, max_service_distance, open_count, status, input ready);
   modport sink (input valid, max_service_distance, open_count, status, output ready);
endinterface
`default_nettype wire

// ===== src/ntft_ram.sv =====
// generic single-write, single-read ram with registered read
`default_nettype none
module ntft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

// ===== src/nearest_two_facility_table.sv =====
// top level of the nearest-two facility table
// Load and clear items give their result in the cycle after they are taken. An
// open or close item walks the nodes in use (node_count capped at the table
// size), one node a cycle through the per-node table memory while no rescan is
// under way. A close rescans the distance row of every node whose first or
// second facility was the closed one, through the single read port of the
// distance matrix memory. A new item is taken once the previous result has
// been delivered. Memories need no clearing pass after reset.
`default_nettype none
module nearest_two_facility_table import ntft_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   ntft_req_if.sink              req,
   ntft_rsp_if.source            rsp,
   input  wire logic             csr_we,
   input  wire logic [CSR_W-1:0] csr_wdata
);
   state_type state_ff, state_in;
   mode_type  mode_ff, mode_in;
   logic [CSR_W-1:0]    node_count_ff;
   logic [CNT_W-1:0]    active;
   logic [IDX_W-1:0]    fac_ff, fac_in;
   logic [CNT_W-1:0]    scan_ff, scan_in;
   logic [IDX_W-1:0]    cur_ff, cur_in;
   logic                pend_ff, pend_in;
   logic [CNT_W-1:0]    rj_ff, rj_in;
   logic [IDX_W-1:0]    rcur_ff, rcur_in;
   logic                rpend_ff, rpend_in;
   logic [CNT_W-1:0]    nf_ff, nf_in, bf_ff, bf_in;
   logic [DIST_W-1:0]   nd_ff, nd_in, bd_ff, bd_in;
   logic [DIST_W-1:0]   max_ff, max_in;
   status_type          status_ff, status_in;
   logic [MAX_NODES-1:0] open_ff, open_in;
   logic [MAX_NODES-1:0] tvalid_ff, tvalid_in;
   logic                tval_q_ff;
   logic [CNT_W-1:0]    open_total_ff, open_total_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0]   rsp_max_ff, rsp_max_in;
   logic [CSR_W-1:0]    rsp_cnt_ff, rsp_cnt_in;
   status_type          rsp_status_ff, rsp_status_in;

   logic                mat_we;
   logic [2*IDX_W-1:0]  mat_waddr, mat_raddr;
   logic [DIST_W-1:0]   mat_rdata;
   logic                tab_we;
   logic [IDX_W-1:0]    tab_waddr;
   entry_type           tab_wdata, tab_rdata, ent;
   logic                accept;
   logic [CNT_W-1:0]    node_x;

   assign active = (node_count_ff > CSR_W'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                      : CNT_W'(node_count_ff);
   assign req.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign accept    = req.valid && req.ready;
   assign node_x    = CNT_W'(req.node);
   assign ent       = tval_q_ff ? tab_rdata : RESET_ENTRY;

   assign mat_waddr = {req.node[IDX_W-1:0], req.other_node[IDX_W-1:0]};
   assign mat_raddr = (state_ff == S_RESCAN) ? {cur_ff, rj_ff[IDX_W-1:0]}
                                             : {fac_ff, scan_ff[IDX_W-1:0]};

   ntft_ram #(.WIDTH(DIST_W), .DEPTH(MAT_DEPTH)) u_matrix (
      .clock (clock),
      .we    (mat_we),
      .waddr (mat_waddr),
      .wdata (req.distance),
      .raddr (mat_raddr),
      .rdata (mat_rdata)
   );

   ntft_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_NODES)) u_table (
      .clock (clock),
      .we    (tab_we),
      .waddr (tab_waddr),
      .wdata (tab_wdata),
      .raddr (scan_ff[IDX_W-1:0]),
      .rdata (tab_rdata)
   );

   always_comb begin
      entry_type ne;
      logic      go_rescan;
      ne            = ent;
      go_rescan     = 1'b0;
      state_in      = state_ff;
      mode_in       = mode_ff;
      fac_in        = fac_ff;
      scan_in       = scan_ff;
      cur_in        = cur_ff;
      pend_in       = pend_ff;
      rj_in         = rj_ff;
      rcur_in       = rcur_ff;
      rpend_in      = rpend_ff;
      nf_in         = nf_ff;
      nd_in         = nd_ff;
      bf_in         = bf_ff;
      bd_in         = bd_ff;
      max_in        = max_ff;
      status_in     = status_ff;
      open_in       = open_ff;
      tvalid_in     = tvalid_ff;
      open_total_in = open_total_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_max_in    = rsp_max_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_status_in = rsp_status_ff;
      mat_we        = 1'b0;
      tab_we        = 1'b0;
      tab_waddr     = cur_ff;
      tab_wdata     = ent;

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (op_type'(req.op))
                  OP_LOAD: begin
                     mat_we        = (CNT_W'(req.node) < CNT_W'(MAX_NODES)) &&
                                     (CNT_W'(req.other_node) < CNT_W'(MAX_NODES));
                     rsp_valid_in  = 1'b1;
                     rsp_max_in    = '0;
                     rsp_cnt_in    = CSR_W'(open_total_ff);
                     rsp_status_in = ST_OK;
                  end
                  OP_CLEAR: begin
                     tvalid_in     = '0;
                     open_in       = '0;
                     open_total_in = '0;
                     rsp_valid_in  = 1'b1;
                     rsp_max_in    = '0;
                     rsp_cnt_in    = '0;
                     rsp_status_in = ST_OK;
                  end
                  default: begin
                     mode_in   = MODE_READ;
                     status_in = ST_OK;
                     if (node_x < active) begin
                        if (req.op == OP_OPEN) begin
                           if (open_ff[req.node[IDX_W-1:0]]) begin
                              status_in = ST_ALREADY_OPEN;
                           end else begin
                              mode_in = MODE_ADD;
                              open_in[req.node[IDX_W-1:0]] = 1'b1;
                              open_total_in = open_total_ff + 1'b1;
                           end
                        end else begin
                           if (!open_ff[req.node[IDX_W-1:0]]) begin
                              status_in = ST_NOT_OPEN;
                           end else begin
                              mode_in = MODE_DEL;
                              open_in[req.node[IDX_W-1:0]] = 1'b0;
                              open_total_in = open_total_ff - 1'b1;
                           end
                        end
                     end
                     fac_in   = req.node[IDX_W-1:0];
                     scan_in  = '0;
                     pend_in  = 1'b0;
                     max_in   = '0;
                     state_in = S_SCAN;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (pend_ff) begin
               case (mode_ff)
                  MODE_ADD: begin
                     if (mat_rdata < ent.nd) begin
                        ne.sf = ent.nf;
                        ne.sd = ent.nd;
                        ne.nf = CNT_W'(fac_ff);
                        ne.nd = mat_rdata;
                     end else if (mat_rdata < ent.sd) begin
                        ne.sf = CNT_W'(fac_ff);
                        ne.sd = mat_rdata;
                     end
                     tab_we            = 1'b1;
                     tab_wdata         = ne;
                     tvalid_in[cur_ff] = 1'b1;
                     if (ne.nd > max_ff) begin
                        max_in = ne.nd;
                     end
                  end
                  MODE_DEL: begin
                     if (ent.nf == CNT_W'(fac_ff)) begin
                        nf_in     = ent.sf;
                        nd_in     = ent.sd;
                        go_rescan = 1'b1;
                     end else if (ent.sf == CNT_W'(fac_ff)) begin
                        nf_in     = ent.nf;
                        nd_in     = ent.nd;
                        go_rescan = 1'b1;
                     end else if (ent.nd > max_ff) begin
                        max_in = ent.nd;
                     end
                  end
                  default: begin
                     if (ent.nd > max_ff) begin
                        max_in = ent.nd;
                     end
                  end
               endcase
            end
            if (go_rescan) begin
               state_in = S_RESCAN;
               scan_in  = CNT_W'(cur_ff) + 1'b1;
               pend_in  = 1'b0;
               rj_in    = '0;
               rpend_in = 1'b0;
               bf_in    = NO_FAC;
               bd_in    = DIST_INF;
            end else if (scan_ff < active) begin
               pend_in = 1'b1;
               cur_in  = scan_ff[IDX_W-1:0];
               scan_in = scan_ff + 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_max_in    = max_ff;
                  rsp_cnt_in    = CSR_W'(open_total_ff);
                  rsp_status_in = status_ff;
                  state_in      = S_IDLE;
               end
            end
         end
         S_RESCAN: begin
            if (rpend_ff && (rcur_ff != cur_ff) && open_ff[rcur_ff] &&
                (CNT_W'(rcur_ff) != nf_ff) && (mat_rdata < bd_ff)) begin
               bd_in = mat_rdata;
               bf_in = CNT_W'(rcur_ff);
            end
            if (rj_ff < active) begin
               rpend_in = 1'b1;
               rcur_in  = rj_ff[IDX_W-1:0];
               rj_in    = rj_ff + 1'b1;
            end else begin
               rpend_in = 1'b0;
               if (!rpend_ff) begin
                  tab_we            = 1'b1;
                  tab_wdata         = '{nf: nf_ff, nd: nd_ff, sf: bf_ff, sd: bd_ff};
                  tvalid_in[cur_ff] = 1'b1;
                  if (nd_ff > max_ff) begin
                     max_in = nd_ff;
                  end
                  state_in = S_SCAN;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         node_count_ff <= CSR_W'(1);
         pend_ff       <= 1'b0;
         rpend_ff      <= 1'b0;
         open_ff       <= '0;
         tvalid_ff     <= '0;
         open_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_ff       <= pend_in;
         rpend_ff      <= rpend_in;
         open_ff       <= open_in;
         tvalid_ff     <= tvalid_in;
         open_total_ff <= open_total_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            node_count_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      fac_ff        <= fac_in;
      scan_ff       <= scan_in;
      cur_ff        <= cur_in;
      rj_ff         <= rj_in;
      rcur_ff       <= rcur_in;
      nf_ff         <= nf_in;
      nd_ff         <= nd_in;
      bf_ff         <= bf_in;
      bd_ff         <= bd_in;
      max_ff        <= max_in;
      status_ff     <= status_in;
      rsp_max_ff    <= rsp_max_in;
      rsp_cnt_ff    <= rsp_cnt_in;
      rsp_status_ff <= rsp_status_in;
      tval_q_ff     <= tvalid_ff[scan_ff[IDX_W-1:0]];
   end

   assign rsp.valid                = rsp_valid_ff;
   assign rsp.max_service_distance = rsp_max_ff;
   assign rsp.open_count           = rsp_cnt_ff;
   assign rsp.status               = rsp_status_ff;
endmodule
`default_nettype wire

// ===== src/ntft_checker.sv =====
// port-level checks for the nearest-two facility table and their binding
`default_nettype none
module ntft_checker import ntft_pkg::*; (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic [OP_W-1:0]     req_op,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [DIST_W-1:0]   rsp_max_service_distance,
   input wire logic [CSR_W-1:0]    rsp_open_count,
   input wire logic [STATUS_W-1:0] rsp_status
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_one_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("item taken while a result is pending");

   a_quick_ops: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_op == OP_LOAD || req_op == OP_CLEAR)
      |=> rsp_valid && rsp_max_service_distance == '0 && rsp_status == ST_OK)
      else $error("load or clear result wrong");

   a_clear_count: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_op == OP_CLEAR |=> rsp_open_count == '0)
      else $error("clear left facilities open");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_open_count <= CSR_W'(MAX_NODES) && rsp_status != 2'd3)
      else $error("result fields out of range");
endmodule

bind nearest_two_facility_table ntft_checker u_ntft_checker (
   .clock                    (clock),
   .reset                    (reset),
   .req_valid                (req.valid),
   .req_ready                (req.ready),
   .req_op                   (req.op),
   .rsp_valid                (rsp.valid),
   .rsp_ready                (rsp.ready),
   .rsp_max_service_distance (rsp.max_service_distance),
   .rsp_open_count           (rsp.open_count),
   .rsp_status               (rsp.status)
);
`default_nettype wire

// ===== sim/tb_nearest_two_facility_table.sv =====
// testbench for the nearest-two facility table: directed and random items checked in order
`timescale 1ns / 1ps
`default_nettype none
module tb_nearest_two_facility_table;
   import ntft_pkg::*;

   localparam int WATCHDOG_LIMIT = 400000;

   typedef struct packed {
      logic [DIST_W-1:0]   max_dist;
      logic [CSR_W-1:0]    opens;
      logic [STATUS_W-1:0] status;
   } service_rsp_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_W-1:0] csr_wdata;

   ntft_req_if req_ch ();
   ntft_rsp_if rsp_ch ();

   nearest_two_facility_table u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   logic [DIST_W-1:0] dist_mem [0:MAT_DEPTH-1];
   logic [CNT_W-1:0]  first_fac [0:MAX_NODES-1];
   logic [DIST_W-1:0] first_dist [0:MAX_NODES-1];
   logic [CNT_W-1:0]  second_fac [0:MAX_NODES-1];
   logic [DIST_W-1:0] second_dist [0:MAX_NODES-1];
   bit                is_open [0:MAX_NODES-1];
   int unsigned       open_total;
   int unsigned       node_limit;

   service_rsp_type pending_rsp [$];
   int  error_count;
   bit  quiet;
   int  idle_cycles;
   int  rsp_stall;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int unsigned nodes_in_use();
      return (node_limit > MAX_NODES) ? MAX_NODES : node_limit;
   endfunction

   function automatic void clear_facilities();
      for (int i = 0; i < MAX_NODES; i++) begin
         first_fac[i]   = NO_FAC;
         second_fac[i]  = NO_FAC;
         first_dist[i]  = DIST_INF;
         second_dist[i] = DIST_INF;
         is_open[i]     = 1'b0;
      end
      open_total = 0;
   endfunction

   function automatic void rescan_second(int v);
      logic [CNT_W-1:0]  best_fac;
      logic [DIST_W-1:0] best_dist;
      logic [DIST_W-1:0] d;
      best_fac  = NO_FAC;
      best_dist = DIST_INF;
      for (int i = 0; i < nodes_in_use(); i++) begin
         if (i != v && is_open[i] && CNT_W'(i) != first_fac[v]) begin
            d = dist_mem[v*MAX_NODES + i];
            if (d < best_dist) begin
               best_dist = d;
               best_fac  = CNT_W'(i);
            end
         end
      end
      second_fac[v]  = best_fac;
      second_dist[v] = best_dist;
   endfunction

   function automatic service_rsp_type predict_service(op_type op, logic [7:0] nd,
                                                       logic [7:0] col, logic [15:0] d);
      service_rsp_type r;
      logic [DIST_W-1:0] dd;
      int n;
      r = '0;
      r.status = ST_OK;
      n = nodes_in_use();
      case (op)
         OP_LOAD: dist_mem[nd*MAX_NODES + col] = d;
         OP_CLEAR: clear_facilities();
         default: begin
            if (nd < n) begin
               if (op == OP_OPEN) begin
                  if (is_open[nd]) begin
                     r.status = ST_ALREADY_OPEN;
                  end else begin
                     is_open[nd] = 1'b1;
                     open_total++;
                     for (int i = 0; i < n; i++) begin
                        dd = dist_mem[nd*MAX_NODES + i];
                        if (dd < first_dist[i]) begin
                           second_dist[i] = first_dist[i];
                           second_fac[i]  = first_fac[i];
                           first_dist[i]  = dd;
                           first_fac[i]   = CNT_W'(nd);
                        end else if (dd < second_dist[i]) begin
                           second_dist[i] = dd;
                           second_fac[i]  = CNT_W'(nd);
                        end
                     end
                  end
               end else begin
                  if (!is_open[nd]) begin
                     r.status = ST_NOT_OPEN;
                  end else begin
                     is_open[nd] = 1'b0;
                     open_total--;
                     for (int i = 0; i < n; i++) begin
                        if (first_fac[i] == CNT_W'(nd)) begin
                           first_dist[i] = second_dist[i];
                           first_fac[i]  = second_fac[i];
                           rescan_second(i);
                        end else if (second_fac[i] == CNT_W'(nd)) begin
                           rescan_second(i);
                        end
                     end
                  end
               end
            end
            for (int i = 0; i < n; i++)
               if (first_dist[i] > r.max_dist) r.max_dist = first_dist[i];
         end
      endcase
      r.opens = CSR_W'(open_total);
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // sends one item; valid stays high after acceptance unless a random gap drops it
   task automatic send_item(op_type op, logic [7:0] nd, logic [7:0] col, logic [15:0] d);
      req_ch.valid      <= 1'b1;
      req_ch.op         <= op;
      req_ch.node       <= nd;
      req_ch.other_node <= col;
      req_ch.distance   <= d;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_rsp.insert(pending_rsp.size(), predict_service(op, nd, col, d));
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_node_count(int unsigned value);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= CSR_W'(value);
      @(posedge clock);
      csr_we    <= 1'b0;
      node_limit = value;
      @(posedge clock);
   endtask

   function automatic logic [15:0] pick_distance();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 16'd0;
      if (r < 20) return DIST_INF;
      if (r < 70) return 16'($urandom_range(0, 15));
      return 16'($urandom);
   endfunction

   task automatic fill_square(int n);
      for (int r = 0; r < n; r++)
         for (int c = 0; c < n; c++)
            send_item(OP_LOAD, 8'(r), 8'(c), pick_distance());
   endtask

   // one node in use after reset
   task automatic test_reset_state();
      send_item(OP_LOAD, 8'd0, 8'd0, 16'd5);
      send_item(OP_OPEN, 8'd0, 8'hff, 16'hffff);
      send_item(OP_OPEN, 8'd0, 8'd0, 16'd0);
      send_item(OP_CLOSE, 8'd0, 8'd0, 16'd0);
      send_item(OP_CLOSE, 8'd0, 8'd0, 16'd0);
      send_item(OP_OPEN, 8'd5, 8'd0, 16'd0);
      send_item(OP_CLEAR, 8'hff, 8'hff, 16'hffff);
   endtask

   // ties, zero and unreachable distances, rescans on four nodes, then a node count of zero
   task automatic test_directed_ops();
      write_node_count(4);
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 4; c++)
            send_item(OP_LOAD, 8'(r), 8'(c),
                      (r == c) ? 16'd0 : ((r + c == 3) ? DIST_INF : 16'd7));
      send_item(OP_OPEN, 8'd1, 8'd0, 16'd0);
      send_item(OP_OPEN, 8'd2, 8'd0, 16'd0);
      send_item(OP_OPEN, 8'd3, 8'd0, 16'd0);
      send_item(OP_OPEN, 8'd0, 8'd0, 16'd0);
      send_item(OP_CLOSE, 8'd1, 8'd0, 16'd0);
      send_item(OP_CLOSE, 8'd3, 8'd0, 16'd0);
      send_item(OP_CLOSE, 8'd0, 8'd0, 16'd0);
      send_item(OP_CLOSE, 8'd2, 8'd0, 16'd0);
      send_item(OP_CLOSE, 8'd2, 8'd0, 16'd0);
      send_item(OP_CLEAR, 8'd0, 8'd0, 16'd0);
      write_node_count(0);
      send_item(OP_OPEN, 8'd0, 8'd0, 16'd0);
      send_item(OP_CLOSE, 8'd0, 8'd0, 16'd0);
   endtask

   // full table size and beyond it; only nodes 0 and 1 become facilities
   // finite distances on rows 0 and 1 keep every scan of a facility row on loaded entries
   task automatic test_full_table();
      write_node_count(MAX_NODES);
      for (int k = 0; k < 2; k++)
         for (int i = 0; i < MAX_NODES; i++)
            send_item(OP_LOAD, 8'(k), 8'(i), 16'($urandom_range(0, 16'hfffe)));
      send_item(OP_OPEN, 8'd0, 8'd0, 16'd0);
      send_item(OP_OPEN, 8'd1, 8'd0, 16'd0);
      send_item(OP_OPEN, 8'd1, 8'd0, 16'd0);
      send_item(OP_CLOSE, 8'd0, 8'd0, 16'd0);
      write_node_count(511);
      send_item(OP_OPEN, 8'd0, 8'd0, 16'd0);
      send_item(OP_CLOSE, 8'd1, 8'd0, 16'd0);
      send_item(OP_CLOSE, 8'd200, 8'd0, 16'd0);
      write_node_count(300);
      send_item(OP_CLOSE, 8'd0, 8'd0, 16'd0);
      send_item(OP_CLEAR, 8'd0, 8'd0, 16'd0);
   endtask

   task automatic test_random_sequences();
      int n;
      int r;
      for (int ph = 0; ph < 5; ph++) begin
         n = (ph == 0) ? 2 : $urandom_range(1, 8);
         write_node_count(n);
         if (ph == 4) quiet = 1'b1;
         send_item(OP_CLEAR, 8'($urandom), 8'($urandom), 16'($urandom));
         fill_square(n);
         for (int k = 0; k < 35; k++) begin
            r = $urandom_range(0, 99);
            if (k == 17 && ph == 2) drain();
            if (r < 45)
               send_item(OP_OPEN, 8'($urandom_range(0, n - 1)), 8'($urandom), 16'($urandom));
            else if (r < 78)
               send_item(OP_CLOSE, 8'($urandom_range(0, n - 1)), 8'($urandom),
                         16'($urandom));
            else if (r < 88)
               send_item(OP_LOAD, 8'($urandom_range(0, n - 1)), 8'($urandom_range(0, n - 1)),
                         pick_distance());
            else if (r < 91)
               send_item(OP_CLEAR, 8'($urandom), 8'($urandom), 16'($urandom));
            else if (r < 95)
               send_item(OP_LOAD, 8'($urandom), 8'($urandom), 16'($urandom));
            else
               send_item(($urandom_range(0, 1) == 0) ? OP_OPEN : OP_CLOSE,
                         8'($urandom_range(n, 255)), 8'($urandom), 16'($urandom));
         end
      end
   endtask

   // response side stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall = 0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         rsp_stall = $urandom_range(1, 13) - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      service_rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected item", 1, 0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_ch.max_service_distance !== want.max_dist)
               report_mismatch("max_service_distance", rsp_ch.max_service_distance,
                               want.max_dist);
            if (rsp_ch.open_count !== want.opens)
               report_mismatch("open_count", rsp_ch.open_count, want.opens);
            if (rsp_ch.status !== want.status)
               report_mismatch("status", rsp_ch.status, want.status);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_wdata         = '0;
      req_ch.valid      = 1'b0;
      req_ch.op         = '0;
      req_ch.node       = '0;
      req_ch.other_node = '0;
      req_ch.distance   = '0;
      error_count       = 0;
      quiet             = 1'b0;
      idle_cycles       = 0;
      node_limit        = 1;
      clear_facilities();
      for (int i = 0; i < MAT_DEPTH; i++) dist_mem[i] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_directed_ops();
      test_full_table();
      test_random_sequences();
      drain();
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule
`default_nettype wire
